@@ src/mrpt_pkg.sv @@
// Shared constants and types for the Miller-Rabin prime test block.
// No dependencies.
`default_nettype none
package mrpt_pkg;
  localparam int unsigned OPERAND_BITS = 63;
  localparam int unsigned CNT_W = $clog2(OPERAND_BITS + 1);
  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [CNT_W-1:0] count_t;
endpackage
`default_nettype wire

@@ src/mrpt_mulmod.sv @@
// Iterative modular multiplier: (x * y) mod m by shift-and-add, one bit per cycle.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mrpt_pkg::operand_t x,
  input  mrpt_pkg::operand_t y,
  input  mrpt_pkg::operand_t m,
  output logic              done,
  output mrpt_pkg::operand_t prod
);
  import mrpt_pkg::*;

  operand_t acc_r, add_r, y_r;
  logic busy_r, done_r;
  logic [OPERAND_BITS:0] s_acc, s_add;
  operand_t acc_nxt, add_nxt;

  always_comb begin
    s_acc = {1'b0, acc_r} + {1'b0, add_r};
    s_add = {1'b0, add_r} + {1'b0, add_r};
    acc_nxt = acc_r;
    if (y_r[0]) begin
      acc_nxt = (s_acc >= {1'b0, m}) ? OPERAND_BITS'(s_acc - {1'b0, m})
                                     : s_acc[OPERAND_BITS-1:0];
    end
    add_nxt = (s_add >= {1'b0, m}) ? OPERAND_BITS'(s_add - {1'b0, m})
                                   : s_add[OPERAND_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        add_r  <= x;
        y_r    <= y;
      end else if (busy_r) begin
        if (y_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          acc_r <= acc_nxt;
          add_r <= add_nxt;
          y_r   <= y_r >> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

@@ src/miller_rabin_prime_test.sv @@
// Miller-Rabin strong probable prime test, bases 2 and 3.
// Depends on mrpt_pkg and mrpt_mulmod.
//
// Usage:
//   Input word: in_candidate on in_valid/in_ready. Result word:
//   out_probably_prime on out_valid/out_ready, one result per candidate.
//   One candidate is processed at a time; in_ready is low while a test
//   runs and while a result waits. Trivial cases (n <= 3, even n) present
//   the result the cycle after acceptance. Otherwise d has at most 62 bits,
//   and each exponent bit costs one check state plus up to two products;
//   squarings trade against exponent bits (bits of d + s <= 63). Every
//   product runs on one shared shift-and-add multiplier. in_ready returns
//   the cycle after the result word is taken.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result. A stalled receiver holds out_valid and the result
//   until out_ready; no new candidate is taken meanwhile.
`default_nettype none
module miller_rabin_prime_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrpt_pkg::operand_t in_candidate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_probably_prime
);
  import mrpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_STRIP, S_BASE, S_PCHK, S_PMUL, S_PSQ, S_YCHK, S_SQ, S_SQCHK, S_OUT
  } state_t;

  state_t   state_r;
  operand_t n_r, d_r, e_r, b_r, y_r;
  count_t   s_r, i_r;
  logic     base3_r, res_r;
  logic     mm_start, mm_done;
  operand_t mm_x, mm_y, mm_prod;
  operand_t nm1;

  assign nm1 = n_r - OPERAND_BITS'(1);

  always_comb begin
    mm_x = y_r;
    mm_y = b_r;
    if (state_r == S_PSQ) begin
      mm_x = b_r;
    end else if (state_r == S_SQ) begin
      mm_y = y_r;
    end
  end

  mrpt_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .x(mm_x), .y(mm_y), .m(n_r),
    .done(mm_done), .prod(mm_prod)
  );

  logic started_r;
  assign mm_start = !started_r &&
    (state_r == S_PMUL || state_r == S_PSQ || state_r == S_SQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mm_start) started_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r     <= in_candidate;
            d_r     <= in_candidate - OPERAND_BITS'(1);
            s_r     <= '0;
            base3_r <= 1'b0;
            if (in_candidate <= OPERAND_BITS'(3) || !in_candidate[0]) begin
              res_r   <= (in_candidate == OPERAND_BITS'(2)) ||
                         (in_candidate == OPERAND_BITS'(3));
              state_r <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              state_r <= S_STRIP;
            end
          end
        end
        S_STRIP: begin
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            s_r <= s_r + count_t'(1);
          end else begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          e_r     <= d_r;
          y_r     <= OPERAND_BITS'(1);
          b_r     <= base3_r ? OPERAND_BITS'(3) : OPERAND_BITS'(2);
          i_r     <= count_t'(1);
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (e_r == '0) state_r <= S_YCHK;
          else if (e_r[0]) state_r <= S_PMUL;
          else state_r <= S_PSQ;
        end
        S_PMUL: begin
          if (mm_done) begin
            y_r <= mm_prod;
            started_r <= 1'b0;
            state_r <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (mm_done) begin
            b_r <= mm_prod;
            e_r <= e_r >> 1;
            started_r <= 1'b0;
            state_r <= S_PCHK;
          end
        end
        S_YCHK: begin
          if (y_r == OPERAND_BITS'(1) || y_r == nm1) begin
            if (base3_r) begin
              res_r <= 1'b1; state_r <= S_OUT; out_valid <= 1'b1;
            end else begin
              base3_r <= 1'b1; state_r <= S_BASE;
            end
          end else if (i_r >= s_r) begin
            res_r <= 1'b0; state_r <= S_OUT; out_valid <= 1'b1;
          end else begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (mm_done) begin
            y_r <= mm_prod;
            i_r <= i_r + count_t'(1);
            started_r <= 1'b0;
            state_r <= S_SQCHK;
          end
        end
        S_SQCHK: begin
          if (y_r == nm1) begin
            if (base3_r) begin
              res_r <= 1'b1; state_r <= S_OUT; out_valid <= 1'b1;
            end else begin
              base3_r <= 1'b1; state_r <= S_BASE;
            end
          end else if (y_r == OPERAND_BITS'(1) || i_r >= s_r) begin
            res_r <= 1'b0; state_r <= S_OUT; out_valid <= 1'b1;
          end else begin
            state_r <= S_SQ;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_probably_prime = res_r;

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("out_valid outside output state");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output overlap");
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> (state_r != S_IDLE)) else $error("multiply started while idle");
endmodule
`default_nettype wire
